FILE: hdl/lpm_pkg.sv
// shared types and constants for the like pattern matcher
package lpm_pkg;

  localparam int PatternMax = 32;
  localparam int CpW        = 21;
  localparam int LenW       = $clog2(PatternMax + 1);
  localparam int IdxW       = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int PosW       = PatternMax + 1;

  typedef logic [CpW-1:0]        cp_t;
  typedef logic [LenW-1:0]       len_t;
  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [PatternMax-1:0] elem_mask_t;
  typedef logic [PosW-1:0]       pos_t;

  localparam cp_t ChBackslash  = cp_t'(21'h5C);
  localparam cp_t ChPercent    = cp_t'(21'h25);
  localparam cp_t ChUnderscore = cp_t'(21'h5F);

  localparam logic ReqPattern = 1'b0;
  localparam logic ReqSubject = 1'b1;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_MATCH  = 2'd2
  } status_t;

  // compiled pattern as seen by the position vector
  typedef struct packed {
    len_t       len;
    logic       err;
    elem_mask_t run;
    elem_mask_t one;
  } pat_info_t;

  // per-transaction outcome of a pattern character
  typedef struct packed {
    logic err_next;
    logic clr_act;
  } pat_ctrl_t;

endpackage

FILE: hdl/like_pattern_matcher.sv
// result path: a verdict or pattern status passes from the input register into the output register
//   once the transaction carrying the last (or empty) character is accepted and the output can take it
// throughput: 1 character per cycle while a full output register is not stalled, set by the update
//   of the position vector, where all 32 pattern elements compare against the character in parallel
// reset: pattern empty and accepted, positions at start, both pipeline registers empty
module like_pattern_matcher (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         req_type,
  input  lpm_pkg::cp_t code_point,
  input  logic         is_last,
  input  logic         is_empty,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   status,
  output logic         matched
);

  // input register
  logic         s1_valid;
  logic         s1_req;
  lpm_pkg::cp_t s1_cp;
  logic         s1_last;
  logic         s1_empty;

  logic         s1_final;
  logic         s1_go;
  logic         pat_go;

  lpm_pkg::pat_info_t info;
  lpm_pkg::pat_ctrl_t ctrl;
  lpm_pkg::cp_t       elem_cp [lpm_pkg::PatternMax];
  logic               hit;

  // every string ends with a result transaction
  assign s1_final = s1_last || s1_empty;
  // the held character retires unless its result would overrun a full output register
  assign s1_go    = s1_valid && (!s1_final || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign pat_go   = s1_go && (s1_req == lpm_pkg::ReqPattern);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req   <= req_type;
      s1_cp    <= code_point;
      s1_last  <= is_last;
      s1_empty <= is_empty;
    end
  end

  lpm_pattern_store u_store (
    .clk        (clk),
    .rst        (rst),
    .go         (pat_go),
    .code_point (s1_cp),
    .is_last    (s1_last),
    .is_empty   (s1_empty),
    .info       (info),
    .elem_cp    (elem_cp),
    .ctrl       (ctrl)
  );

  lpm_position_vector u_pos (
    .clk        (clk),
    .rst        (rst),
    .go         (s1_go),
    .req_type   (s1_req),
    .code_point (s1_cp),
    .is_last    (s1_last),
    .is_empty   (s1_empty),
    .info       (info),
    .elem_cp    (elem_cp),
    .ctrl       (ctrl),
    .hit        (hit)
  );

  // output register: pattern status or subject verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_final) begin
      if (s1_req == lpm_pkg::ReqPattern) begin
        status  <= ctrl.err_next ? lpm_pkg::ST_REJECT : lpm_pkg::ST_ACCEPT;
        matched <= 1'b0;
      end else begin
        // a rejected pattern never matches
        status  <= lpm_pkg::ST_MATCH;
        matched <= hit && !info.err;
      end
    end
  end

endmodule

FILE: hdl/lpm_pattern_store.sv
// pattern compiler and element store
module lpm_pattern_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  lpm_pkg::cp_t       code_point,
  input  logic               is_last,
  input  logic               is_empty,
  output lpm_pkg::pat_info_t info,
  output lpm_pkg::cp_t       elem_cp [lpm_pkg::PatternMax],
  output lpm_pkg::pat_ctrl_t ctrl
);

  logic                loading;
  lpm_pkg::len_t       len;
  logic                esc;
  logic                err;
  logic                lws;
  lpm_pkg::elem_mask_t run_flag;
  lpm_pkg::elem_mask_t one_flag;

  logic                start;
  lpm_pkg::len_t       len0;
  logic                esc0, err0, lws0;
  lpm_pkg::len_t       len_next;
  logic                esc_next, err_next, lws_next;
  logic                app;
  lpm_pkg::kind_t      app_kind;
  lpm_pkg::cp_t        app_cp;
  logic                wr_en;

  always_comb begin
    start    = is_empty || !loading;
    len0     = start ? '0 : len;
    esc0     = start ? 1'b0 : esc;
    err0     = start ? 1'b0 : err;
    lws0     = start ? 1'b0 : lws;
    len_next = len0;
    esc_next = esc0;
    err_next = err0;
    lws_next = lws0;
    app      = 1'b0;
    app_kind = lpm_pkg::KIND_LIT;
    app_cp   = code_point;
    wr_en    = 1'b0;
    if (!is_empty && !err0) begin
      if (esc0) begin
        esc_next = 1'b0;
        if (code_point == lpm_pkg::ChPercent || code_point == lpm_pkg::ChUnderscore) begin
          app      = 1'b1;
          lws_next = 1'b0;
        end else begin
          err_next = 1'b1;
        end
      end else if (code_point == lpm_pkg::ChBackslash) begin
        esc_next = 1'b1;
      end else if (code_point == lpm_pkg::ChPercent) begin
        // a run of percents is one element
        app      = !lws0;
        app_kind = lpm_pkg::KIND_RUN;
        app_cp   = '0;
        lws_next = 1'b1;
      end else if (code_point == lpm_pkg::ChUnderscore) begin
        app      = 1'b1;
        app_kind = lpm_pkg::KIND_ONE;
        app_cp   = '0;
        lws_next = 1'b0;
      end else begin
        app      = 1'b1;
        lws_next = 1'b0;
      end
    end
    if (app) begin
      if (len0 >= lpm_pkg::len_t'(lpm_pkg::PatternMax)) begin
        err_next = 1'b1;
      end else begin
        wr_en    = 1'b1;
        len_next = len0 + lpm_pkg::len_t'(1);
      end
    end
  end

  assign ctrl.err_next = err_next;
  assign ctrl.clr_act  = start || is_empty || is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      loading <= 1'b0;
      len     <= '0;
      esc     <= 1'b0;
      err     <= 1'b0;
      lws     <= 1'b0;
    end else if (go) begin
      loading <= !(is_empty || is_last);
      len     <= len_next;
      esc     <= esc_next;
      err     <= err_next;
      lws     <= lws_next;
    end
  end

  // element store, no reset: only entries below len are ever used
  always_ff @(posedge clk) begin
    if (go && wr_en) begin
      run_flag[len0[lpm_pkg::IdxW-1:0]] <= (app_kind == lpm_pkg::KIND_RUN);
      one_flag[len0[lpm_pkg::IdxW-1:0]] <= (app_kind == lpm_pkg::KIND_ONE);
      elem_cp[len0[lpm_pkg::IdxW-1:0]]  <= app_cp;
    end
  end

  assign info.len = len;
  assign info.err = err;
  assign info.run = run_flag;
  assign info.one = one_flag;

endmodule

FILE: hdl/lpm_position_vector.sv
// bit-parallel active position vector and match verdict
module lpm_position_vector (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic               req_type,
  input  lpm_pkg::cp_t       code_point,
  input  logic               is_last,
  input  logic               is_empty,
  input  lpm_pkg::pat_info_t info,
  input  lpm_pkg::cp_t       elem_cp [lpm_pkg::PatternMax],
  input  lpm_pkg::pat_ctrl_t ctrl,
  output logic               hit
);

  lpm_pkg::pos_t       act;
  lpm_pkg::pos_t       act_closed;
  lpm_pkg::pos_t       act_new;
  lpm_pkg::pos_t       act_final;
  lpm_pkg::elem_mask_t vmask;
  lpm_pkg::elem_mask_t run_v;
  lpm_pkg::elem_mask_t step;
  lpm_pkg::elem_mask_t stay;

  // a run element lets a position move on without a character;
  // run elements are never adjacent, so one step suffices
  function automatic lpm_pkg::pos_t close_runs(lpm_pkg::pos_t a, lpm_pkg::elem_mask_t run);
    return a | {run & a[lpm_pkg::PatternMax-1:0], 1'b0};
  endfunction

  always_comb begin
    for (int i = 0; i < lpm_pkg::PatternMax; i++) begin
      vmask[i] = lpm_pkg::len_t'(i) < info.len;
    end
    run_v      = info.run & vmask;
    act_closed = close_runs(act, run_v);
    for (int i = 0; i < lpm_pkg::PatternMax; i++) begin
      stay[i] = act_closed[i] && run_v[i];
      step[i] = act_closed[i] && vmask[i] && !info.run[i] &&
                (info.one[i] || (elem_cp[i] == code_point));
    end
    act_new   = is_empty ? lpm_pkg::pos_t'(1)
                         : ({step, 1'b0} | {1'b0, stay});
    act_final = close_runs(act_new, run_v);
    hit       = act_final[info.len];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= lpm_pkg::pos_t'(1);
    end else if (go) begin
      if (req_type == lpm_pkg::ReqPattern) begin
        if (ctrl.clr_act) begin
          act <= lpm_pkg::pos_t'(1);
        end
      end else if (is_empty || is_last) begin
        act <= lpm_pkg::pos_t'(1);
      end else begin
        act <= act_new;
      end
    end
  end

endmodule

FILE: hdl/lpm_checker.sv
// port-level checker for the like pattern matcher, with its bind
module lpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       matched
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(matched))
    else $error("result transaction dropped or changed while stalled");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == lpm_pkg::ST_ACCEPT || status == lpm_pkg::ST_REJECT ||
                  status == lpm_pkg::ST_MATCH)
    else $error("illegal status code");

  a_matched_only_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lpm_pkg::ST_MATCH |-> !matched)
    else $error("matched set on a pattern status");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind like_pattern_matcher lpm_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .matched   (matched)
);
